// ===== hdl/uflow_pkg.sv =====
// Shared types and constants for the UART flow-control byte queues.
// Holds the item structs, event codes and default settings.
// No dependencies.
package uflow_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned HW_W            = 6;
  localparam int unsigned LEVEL_W         = 6;
  localparam logic [HW_W-1:0] RTS_THRESH_RST = 6'd48;

  typedef enum logic [1:0] {
    FUNC_RX_BYTE   = 2'd0,
    FUNC_HOST_READ = 2'd1,
    FUNC_HOST_WR   = 2'd2,
    FUNC_TX_READY  = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               data_valid;
    logic               accepted;
    logic               rts_n;
    logic               rx_overflow;
    logic               tx_primed;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } out_item_t;

endpackage

// ===== hdl/uart_flow_control_fifo_top.sv =====
// Top level of the UART receive/transmit byte queues with RTS flow control.
// Depends on uflow_pkg and two instances of uflow_ram.
//
//   channel | ports                        | handshake
//   --------+------------------------------+-----------------------------------
//   input   | start, busy, in_item         | taken when start & !busy
//   result  | out_strobe, out_item         | one cycle, no back-pressure
//   config  | cfg_we, cfg_wdata            | RTS threshold written when cfg_we
//
// Each result appears the cycle after its item is taken, with the dequeued
// byte coming from the registered RAM read port.
// A new item can be taken in every cycle; busy stays low.
// Reset is synchronous and clears pointers, counts and flags; the byte stores
// are not cleared, since a slot is only read after it has been written.
module uart_flow_control_fifo_top #(
  parameter int unsigned QUEUE_DEPTH = uflow_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  uflow_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output uflow_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [uflow_pkg::HW_W-1:0] cfg_wdata
);

  import uflow_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CMP_W = (PTR_W > HW_W) ? PTR_W : HW_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0] FULL_CNT  = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] rx_rd_r, rx_rd_nxt, rx_wr_r, rx_wr_nxt, rx_cnt_r, rx_cnt_nxt;
  logic [PTR_W-1:0] tx_rd_r, tx_rd_nxt, tx_wr_r, tx_wr_nxt, tx_cnt_r, tx_cnt_nxt;
  logic             ovf_r, ovf_nxt, primed_r, primed_nxt, rts_r, rts_nxt;
  logic [HW_W-1:0]  rts_thresh_r;
  logic             strobe_r, valid_r, valid_nxt, stored_r, stored_nxt;
  logic             sel_tx_r, sel_tx_nxt;
  logic             take;
  logic             rx_push, rx_pop, tx_push, tx_pop;
  logic [7:0]       rx_rdata, tx_rdata;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign busy = 1'b0;
  assign take = start & ~busy;

  always_comb begin
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    ovf_nxt    = ovf_r;
    primed_nxt = primed_r;
    rts_nxt    = rts_r;
    valid_nxt  = 1'b0;
    stored_nxt = 1'b0;
    sel_tx_nxt = 1'b0;
    rx_cnt_nxt = rx_cnt_r;
    unique case (in_item.func)
      FUNC_RX_BYTE: begin
        if (rx_cnt_r != FULL_CNT) begin
          rx_push    = 1'b1;
          stored_nxt = 1'b1;
          rx_cnt_nxt = rx_cnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        if (CMP_W'(rx_cnt_nxt) > CMP_W'(rts_thresh_r)) begin
          rts_nxt = 1'b1;
        end
      end
      FUNC_HOST_READ: begin
        if (rx_cnt_r != '0) begin
          rx_pop     = 1'b1;
          valid_nxt  = 1'b1;
          rx_cnt_nxt = rx_cnt_r - 1'b1;
        end
        if (CMP_W'(rx_cnt_nxt) <= CMP_W'(rts_thresh_r)) begin
          rts_nxt = 1'b0;
        end
      end
      FUNC_HOST_WR: begin
        // The sender is primed even when the byte is dropped.
        primed_nxt = 1'b1;
        if (tx_cnt_r != FULL_CNT) begin
          tx_push    = 1'b1;
          stored_nxt = 1'b1;
        end
      end
      FUNC_TX_READY: begin
        sel_tx_nxt = 1'b1;
        if (primed_r) begin
          if (tx_cnt_r != '0) begin
            tx_pop    = 1'b1;
            valid_nxt = 1'b1;
          end else begin
            primed_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    rx_push = rx_push & take;
    rx_pop  = rx_pop & take;
    tx_push = tx_push & take;
    tx_pop  = tx_pop & take;
  end

  always_comb begin
    rx_wr_nxt  = rx_push ? next_slot(rx_wr_r) : rx_wr_r;
    rx_rd_nxt  = rx_pop ? next_slot(rx_rd_r) : rx_rd_r;
    tx_wr_nxt  = tx_push ? next_slot(tx_wr_r) : tx_wr_r;
    tx_rd_nxt  = tx_pop ? next_slot(tx_rd_r) : tx_rd_r;
    tx_cnt_nxt = tx_cnt_r;
    if (tx_push) begin
      tx_cnt_nxt = tx_cnt_r + 1'b1;
    end else if (tx_pop) begin
      tx_cnt_nxt = tx_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_rd_r      <= '0;
      rx_wr_r      <= '0;
      rx_cnt_r     <= '0;
      tx_rd_r      <= '0;
      tx_wr_r      <= '0;
      tx_cnt_r     <= '0;
      ovf_r        <= 1'b0;
      primed_r     <= 1'b0;
      rts_r        <= 1'b0;
      rts_thresh_r <= RTS_THRESH_RST;
      strobe_r     <= 1'b0;
      valid_r      <= 1'b0;
      stored_r     <= 1'b0;
      sel_tx_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rts_thresh_r <= cfg_wdata;
      end
      strobe_r <= take;
      rx_rd_r  <= rx_rd_nxt;
      rx_wr_r  <= rx_wr_nxt;
      tx_rd_r  <= tx_rd_nxt;
      tx_wr_r  <= tx_wr_nxt;
      tx_cnt_r <= tx_cnt_nxt;
      if (take) begin
        rx_cnt_r <= rx_cnt_nxt;
        ovf_r    <= ovf_nxt;
        primed_r <= primed_nxt;
        rts_r    <= rts_nxt;
        valid_r  <= valid_nxt;
        stored_r <= stored_nxt;
        sel_tx_r <= sel_tx_nxt;
      end
    end
  end

  uflow_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_push),
    .waddr(rx_wr_r),
    .wdata(in_item.data_in),
    .re   (rx_pop),
    .raddr(rx_rd_r),
    .rdata(rx_rdata)
  );

  uflow_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_push),
    .waddr(tx_wr_r),
    .wdata(in_item.data_in),
    .re   (tx_pop),
    .raddr(tx_rd_r),
    .rdata(tx_rdata)
  );

  // The state registers already hold the values after the item, so the
  // result reads them directly in the cycle after it was taken.
  assign out_strobe           = strobe_r;
  assign out_item.data_out    = valid_r ? (sel_tx_r ? tx_rdata : rx_rdata) : 8'h00;
  assign out_item.data_valid  = valid_r;
  assign out_item.accepted    = stored_r;
  assign out_item.rts_n       = rts_r;
  assign out_item.rx_overflow = ovf_r;
  assign out_item.tx_primed   = primed_r;
  assign out_item.rx_level    = LEVEL_W'(rx_cnt_r);
  assign out_item.tx_level    = LEVEL_W'(tx_cnt_r);

endmodule

// ===== hdl/uflow_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module uflow_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb_uart_flow_control_fifo_top.sv =====
// Testbench for uart_flow_control_fifo_top: drives receive, host read, host write and
// transmit-ready items, predicts every status result and checks it field by field.
// Depends on uflow_pkg and the RTL of the top level.
module tb_uart_flow_control_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uflow_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_strobe;
  out_item_t           out_item;
  logic                cfg_we;
  logic [HW_W-1:0]     cfg_wdata;

  // Prediction state: two byte rings with one slot always left free.
  logic [7:0]          rx_bytes [64];
  logic [7:0]          tx_bytes [64];
  logic [5:0]          rx_rd, rx_wr, tx_rd, tx_wr;
  logic                overflow_seen, sender_primed, rts_hold;
  logic [HW_W-1:0]     hw_level;

  out_item_t           expected_status [$];
  int                  fail_count;
  bit                  idle_on;

  uart_flow_control_fifo_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic in_item_t make_item(input func_t f, input logic [7:0] d);
    in_item_t it;
    it.func    = f;
    it.data_in = d;
    return it;
  endfunction

  // Computes the status after one event and queues it as the expected result.
  task automatic apply_uart_event(input in_item_t it);
    out_item_t st;
    st = '0;
    case (it.func)
      FUNC_RX_BYTE: begin
        if (rx_wr + 6'd1 != rx_rd) begin
          rx_bytes[rx_wr] = it.data_in;
          rx_wr           = rx_wr + 6'd1;
          st.accepted     = 1'b1;
        end else begin
          overflow_seen = 1'b1;
        end
        if (6'(rx_wr - rx_rd) > hw_level) begin
          rts_hold = 1'b1;
        end
      end
      FUNC_HOST_READ: begin
        if (rx_rd != rx_wr) begin
          st.data_out   = rx_bytes[rx_rd];
          st.data_valid = 1'b1;
          rx_rd         = rx_rd + 6'd1;
        end
        if (6'(rx_wr - rx_rd) <= hw_level) begin
          rts_hold = 1'b0;
        end
      end
      FUNC_HOST_WR: begin
        if (tx_wr + 6'd1 != tx_rd) begin
          tx_bytes[tx_wr] = it.data_in;
          tx_wr           = tx_wr + 6'd1;
          st.accepted     = 1'b1;
        end
        sender_primed = 1'b1;
      end
      default: begin
        // Transmit ready does nothing unless the sender is primed.
        if (sender_primed) begin
          if (tx_rd != tx_wr) begin
            st.data_out   = tx_bytes[tx_rd];
            st.data_valid = 1'b1;
            tx_rd         = tx_rd + 6'd1;
          end else begin
            sender_primed = 1'b0;
          end
        end
      end
    endcase
    st.rts_n       = rts_hold;
    st.rx_overflow = overflow_seen;
    st.tx_primed   = sender_primed;
    st.rx_level    = 6'(rx_wr - rx_rd);
    st.tx_level    = 6'(tx_wr - tx_rd);
    expected_status.push_back(st);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (expected_status.size() == 0) begin
        note_failure("result strobe with no item pending");
      end else begin
        want = expected_status.pop_front();
        compare_field("data_out",    want.data_out,    out_item.data_out);
        compare_field("data_valid",  want.data_valid,  out_item.data_valid);
        compare_field("accepted",    want.accepted,    out_item.accepted);
        compare_field("rts_n",       want.rts_n,       out_item.rts_n);
        compare_field("rx_overflow", want.rx_overflow, out_item.rx_overflow);
        compare_field("tx_primed",   want.tx_primed,   out_item.tx_primed);
        compare_field("rx_level",    want.rx_level,    out_item.rx_level);
        compare_field("tx_level",    want.tx_level,    out_item.tx_level);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    apply_uart_event(it);
  endtask

  task automatic send_event(input func_t f);
    send_item(make_item(f, 8'($urandom_range(0, 255))));
  endtask

  // Results come one per item, so the block is idle once nothing is pending.
  task automatic set_rts_thresh(input logic [HW_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    hw_level = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_basic_events();
    send_item(make_item(FUNC_TX_READY,  8'hA5));
    send_item(make_item(FUNC_HOST_READ, 8'h00));
    send_item(make_item(FUNC_RX_BYTE,   8'h00));
    send_item(make_item(FUNC_RX_BYTE,   8'hFF));
    send_item(make_item(FUNC_RX_BYTE,   8'h5A));
    send_item(make_item(FUNC_HOST_READ, 8'h00));
    send_item(make_item(FUNC_HOST_READ, 8'hFF));
    send_item(make_item(FUNC_HOST_READ, 8'h33));
    send_item(make_item(FUNC_HOST_READ, 8'hFF));
    send_item(make_item(FUNC_HOST_WR,   8'hFF));
    send_item(make_item(FUNC_HOST_WR,   8'h00));
    send_item(make_item(FUNC_TX_READY,  8'h00));
    send_item(make_item(FUNC_TX_READY,  8'hFF));
    send_item(make_item(FUNC_TX_READY,  8'h00));
    send_item(make_item(FUNC_TX_READY,  8'hFF));
    send_item(make_item(FUNC_HOST_WR,   8'h81));
    send_item(make_item(FUNC_TX_READY,  8'h00));
  endtask

  // Fill the receive ring past full, then read it back past empty.
  task automatic fill_and_drain_rx();
    int extra;
    extra = $urandom_range(1, 3);
    repeat (63 + extra) send_event(FUNC_RX_BYTE);
    repeat (63 + extra) send_event(FUNC_HOST_READ);
  endtask

  task automatic test_rx_flow_control();
    fill_and_drain_rx();
    set_rts_thresh(6'd0);
    fill_and_drain_rx();
    set_rts_thresh(6'd63);
    fill_and_drain_rx();
    set_rts_thresh(6'($urandom_range(1, 62)));
    fill_and_drain_rx();
  endtask

  // Host writes into a full transmit ring still prime the sender.
  task automatic test_tx_backlog();
    repeat (2) begin
      repeat (63 + $urandom_range(1, 3)) send_event(FUNC_HOST_WR);
      repeat (63 + $urandom_range(1, 3)) send_event(FUNC_TX_READY);
    end
  endtask

  task automatic test_random_mix(input int n_items);
    int w_rx, w_rd, w_wr, w_tx, r;
    func_t f;
    w_rx = 25; w_rd = 25; w_wr = 25; w_tx = 25;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        w_rx = $urandom_range(5, 60);
        w_rd = $urandom_range(5, 60);
        w_wr = $urandom_range(5, 40);
        w_tx = $urandom_range(5, 40);
      end
      if (i % 200 == 100) begin
        case ($urandom_range(0, 2))
          0:       set_rts_thresh(6'd0);
          1:       set_rts_thresh(6'd63);
          default: set_rts_thresh(6'($urandom_range(0, 63)));
        endcase
      end
      // The last stretch runs back to back, apart from threshold writes.
      if (i == n_items - 250) idle_on = 1'b0;
      r = $urandom_range(0, w_rx + w_rd + w_wr + w_tx - 1);
      if (r < w_rx) f = FUNC_RX_BYTE;
      else if (r < w_rx + w_rd) f = FUNC_HOST_READ;
      else if (r < w_rx + w_rd + w_wr) f = FUNC_HOST_WR;
      else f = FUNC_TX_READY;
      send_event(f);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    idle_on       = 1'b1;
    fail_count    = 0;
    rx_rd         = '0;
    rx_wr         = '0;
    tx_rd         = '0;
    tx_wr         = '0;
    overflow_seen = 1'b0;
    sender_primed = 1'b0;
    rts_hold      = 1'b0;
    hw_level      = RTS_THRESH_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_events();
    test_rx_flow_control();
    test_tx_backlog();
    test_random_mix(1050);

    @(negedge clk);
    start <= 1'b0;
    for (int k = 0; k < 1000 && expected_status.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_status.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_status.size()));
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
